[src/snx_pkg.sv]
// Shared constants, lookup tables and helper functions for the 3D simplex noise block.
// No dependencies; compile first.
package snx_pkg;

    localparam int FRAC_BITS_DEF     = 16;
    localparam int OUT_FRAC_BITS_DEF = 14;

    localparam int COORD_W  = 32;   // input coordinate width
    localparam int OUT_W    = 16;   // noise output width
    localparam int INT_FRAC = 24;   // internal fraction bits of corner offsets

    // corner offset conversion: exact /6 via halving and reciprocal /3
    localparam int VW       = 29;   // offset numerator width
    localparam int DIV3_SH  = 31;
    localparam int DIV3_W   = 30;
    localparam logic [DIV3_W-1:0] DIV3_R    = 30'd715827883; // ceil(2^31 / 3)
    localparam logic [VW-1:0]     DIV3_BIAS = 29'd402653184; // 3 * 2^27
    localparam int PM_W     = VW + DIV3_W;
    localparam int OFF_W    = 26;   // corner offset, INT_FRAC fraction bits

    localparam int SQ_W     = 50;
    localparam int R2_W     = 52;
    localparam int T_W      = 24;
    localparam int TT_W     = 48;
    localparam int DOT_W    = 27;
    localparam int CON_W    = 52;
    localparam int SUM_W    = 54;

    localparam logic [R2_W-1:0] C06    = 52'd168884986026394; // 0.6 at 48 fraction bits
    localparam logic [R2_W-1:0] T_RND  = 52'd8388608;         // half LSB at 24 bits
    localparam logic [TT_W-1:0] TT_RND = 48'd8388608;

    localparam logic [7:0] PERM [256] = '{
        8'd151, 8'd160, 8'd137, 8'd91,  8'd90,  8'd15,  8'd131, 8'd13,
        8'd201, 8'd95,  8'd96,  8'd53,  8'd194, 8'd233, 8'd7,   8'd225,
        8'd140, 8'd36,  8'd103, 8'd30,  8'd69,  8'd142, 8'd8,   8'd99,
        8'd37,  8'd240, 8'd21,  8'd10,  8'd23,  8'd190, 8'd6,   8'd148,
        8'd247, 8'd120, 8'd234, 8'd75,  8'd0,   8'd26,  8'd197, 8'd62,
        8'd94,  8'd252, 8'd219, 8'd203, 8'd117, 8'd35,  8'd11,  8'd32,
        8'd57,  8'd177, 8'd33,  8'd88,  8'd237, 8'd149, 8'd56,  8'd87,
        8'd174, 8'd20,  8'd125, 8'd136, 8'd171, 8'd168, 8'd68,  8'd175,
        8'd74,  8'd165, 8'd71,  8'd134, 8'd139, 8'd48,  8'd27,  8'd166,
        8'd77,  8'd146, 8'd158, 8'd231, 8'd83,  8'd111, 8'd229, 8'd122,
        8'd60,  8'd211, 8'd133, 8'd230, 8'd220, 8'd105, 8'd92,  8'd41,
        8'd55,  8'd46,  8'd245, 8'd40,  8'd244, 8'd102, 8'd143, 8'd54,
        8'd65,  8'd25,  8'd63,  8'd161, 8'd1,   8'd216, 8'd80,  8'd73,
        8'd209, 8'd76,  8'd132, 8'd187, 8'd208, 8'd89,  8'd18,  8'd169,
        8'd200, 8'd196, 8'd135, 8'd130, 8'd116, 8'd188, 8'd159, 8'd86,
        8'd164, 8'd100, 8'd109, 8'd198, 8'd173, 8'd186, 8'd3,   8'd64,
        8'd52,  8'd217, 8'd226, 8'd250, 8'd124, 8'd123, 8'd5,   8'd202,
        8'd38,  8'd147, 8'd118, 8'd126, 8'd255, 8'd82,  8'd85,  8'd212,
        8'd207, 8'd206, 8'd59,  8'd227, 8'd47,  8'd16,  8'd58,  8'd17,
        8'd182, 8'd189, 8'd28,  8'd42,  8'd223, 8'd183, 8'd170, 8'd213,
        8'd119, 8'd248, 8'd152, 8'd2,   8'd44,  8'd154, 8'd163, 8'd70,
        8'd221, 8'd153, 8'd101, 8'd155, 8'd167, 8'd43,  8'd172, 8'd9,
        8'd129, 8'd22,  8'd39,  8'd253, 8'd19,  8'd98,  8'd108, 8'd110,
        8'd79,  8'd113, 8'd224, 8'd232, 8'd178, 8'd185, 8'd112, 8'd104,
        8'd218, 8'd246, 8'd97,  8'd228, 8'd251, 8'd34,  8'd242, 8'd193,
        8'd238, 8'd210, 8'd144, 8'd12,  8'd191, 8'd179, 8'd162, 8'd241,
        8'd81,  8'd51,  8'd145, 8'd235, 8'd249, 8'd14,  8'd239, 8'd107,
        8'd49,  8'd192, 8'd214, 8'd31,  8'd181, 8'd199, 8'd106, 8'd157,
        8'd184, 8'd84,  8'd204, 8'd176, 8'd115, 8'd121, 8'd50,  8'd45,
        8'd127, 8'd4,   8'd150, 8'd254, 8'd138, 8'd236, 8'd205, 8'd93,
        8'd222, 8'd114, 8'd67,  8'd29,  8'd24,  8'd72,  8'd243, 8'd141,
        8'd128, 8'd195, 8'd78,  8'd66,  8'd215, 8'd61,  8'd156, 8'd180
    };

    // gradient components; the last four rows are never selected
    localparam logic signed [1:0] GRAD_X [16] = '{
        2'sd1, -2'sd1, 2'sd1, -2'sd1, 2'sd1, -2'sd1, 2'sd1, -2'sd1,
        2'sd0, 2'sd0, 2'sd0, 2'sd0, 2'sd0, 2'sd0, 2'sd0, 2'sd0
    };
    localparam logic signed [1:0] GRAD_Y [16] = '{
        2'sd1, 2'sd1, -2'sd1, -2'sd1, 2'sd0, 2'sd0, 2'sd0, 2'sd0,
        2'sd1, -2'sd1, 2'sd1, -2'sd1, 2'sd0, 2'sd0, 2'sd0, 2'sd0
    };
    localparam logic signed [1:0] GRAD_Z [16] = '{
        2'sd0, 2'sd0, 2'sd0, 2'sd0, 2'sd1, 2'sd1, -2'sd1, -2'sd1,
        2'sd1, 2'sd1, -2'sd1, -2'sd1, 2'sd0, 2'sd0, 2'sd0, 2'sd0
    };

    // v mod 12 for an 8-bit value; quotient by reciprocal 171 / 2^11
    function automatic logic [3:0] perm_mod12(input logic [7:0] v);
        logic [15:0] p;
        logic [4:0]  q;
        logic [7:0]  r;
        p = {8'd0, v} * 16'd171;
        q = p[15:11];
        r = v - ({3'd0, q} * 8'd12);
        return r[3:0];
    endfunction

    function automatic logic signed [DOT_W-1:0] grad_term(
        input logic signed [1:0]       gc,
        input logic signed [OFF_W-1:0] v
    );
        logic signed [DOT_W-1:0] ve;
        ve = DOT_W'(v);
        if (gc == 2'sd0)
            return '0;
        else if (gc[1])
            return -ve;
        else
            return ve;
    endfunction

    function automatic logic signed [DOT_W-1:0] grad_dot(
        input logic [3:0]              g,
        input logic signed [OFF_W-1:0] x,
        input logic signed [OFF_W-1:0] y,
        input logic signed [OFF_W-1:0] z
    );
        return grad_term(GRAD_X[g], x) + grad_term(GRAD_Y[g], y) + grad_term(GRAD_Z[g], z);
    endfunction

endpackage

[src/snx_if.sv]
// Valid/ready channel interfaces for the simplex noise block: point input, noise output.
// Depends on snx_pkg for field widths.
interface snx_in_if import snx_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] x_coord;
    logic signed [COORD_W-1:0] y_coord;
    logic signed [COORD_W-1:0] z_coord;

    modport source (output valid, output x_coord, output y_coord, output z_coord, input ready);
    modport sink   (input valid, input x_coord, input y_coord, input z_coord, output ready);
endinterface

interface snx_out_if import snx_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] noise_value;

    modport source (output valid, output noise_value, input ready);
    modport sink   (input valid, input noise_value, output ready);
endinterface

[src/simplex_noise_3d.sv]
// 3D simplex noise, fixed point, fully pipelined top level.
// Depends on snx_pkg and the channel interfaces in snx_if.sv.
//
//  channel  | dir | payload                               | transaction
//  ---------+-----+---------------------------------------+-----------------------
//  in_ch    | in  | x_coord, y_coord, z_coord (Q.FRAC)    | valid & ready
//  out_ch   | out | noise_value (Q.OUT_FRAC, saturated)   | valid & ready
//
// One transaction in per cycle, one out per cycle, while out_ch does not stall;
// between acceptance and the result showing on out_ch lie 13 datapath stages
// plus the output register. The whole pipe advances together whenever the output
// register is empty or being taken, so a stall on out_ch freezes every stage
// and nothing is lost or repeated. Reset clears only the valid bits.
module simplex_noise_3d import snx_pkg::*; #(
    parameter int FRAC_BITS     = FRAC_BITS_DEF,
    parameter int OUT_FRAC_BITS = OUT_FRAC_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    snx_in_if.sink      in_ch,
    snx_out_if.source   out_ch
);

    // skew sum 4a+b+c, then floor by 2^F, then floor by 3 via reciprocal
    localparam int F     = FRAC_BITS;
    localparam int SIN_W = COORD_W + 3;
    localparam int QW    = SIN_W - F;
    localparam int UW    = QW + 1;
    localparam int MW    = QW + 2;
    localparam int DM    = QW + 3;
    localparam int PW    = UW + MW;
    localparam logic [MW-1:0] CELL_M    = MW'(((64'd1 << DM) + 64'd2) / 64'd3);
    localparam logic [UW-1:0] CELL_BIAS = UW'(64'd3 << (QW - 1));

    // in-cell offsets in units of 1/(6*2^F); |n| < 9*2^F
    localparam int NW = F + 5;
    localparam int LW = NW - F;
    localparam logic [NW-1:0] SIX_N = NW'(6) << F;

    localparam int SH = 2 * INT_FRAC - 5 - OUT_FRAC_BITS;
    localparam logic signed [SUM_W-1:0] OUT_RND = SUM_W'(1) <<< (SH - 1);
    localparam logic signed [SUM_W-1:0] SAT_HI  = (SUM_W'(1) <<< (OUT_W - 1)) - SUM_W'(1);
    localparam logic signed [SUM_W-1:0] SAT_LO  = -(SUM_W'(1) <<< (OUT_W - 1));

    localparam int NST = 13;

    logic           adv;
    logic [NST-1:0] vld_reg;
    logic           o_valid_reg;
    logic signed [OUT_W-1:0] o_noise_reg;
    logic signed [OUT_W-1:0] o_noise_next;

    // pipe moves when the output register is free or draining
    assign adv         = !o_valid_reg || out_ch.ready;
    assign in_ch.ready = adv;
    assign out_ch.valid       = o_valid_reg;
    assign out_ch.noise_value = o_noise_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg     <= '0;
            o_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg     <= {vld_reg[NST-2:0], in_ch.valid};
            o_valid_reg <= vld_reg[NST-1];
        end
    end

    // ---------------- stage 1: skew sums, floor by 2^F ----------------
    logic signed [COORD_W-1:0] crd [3];
    logic signed [QW-1:0]      q1_next  [3];
    logic signed [QW-1:0]      q1_reg   [3];
    logic [NW-1:0]             xl1_reg  [3];
    logic [NW-1:0]             xl2_reg  [3];

    assign crd[0] = in_ch.x_coord;
    assign crd[1] = in_ch.y_coord;
    assign crd[2] = in_ch.z_coord;

    always_comb
    begin
        logic signed [SIN_W-1:0] tot;
        logic signed [SIN_W-1:0] s4;
        tot = SIN_W'(crd[0]) + SIN_W'(crd[1]) + SIN_W'(crd[2]);
        for (int a = 0; a < 3; a++)
        begin
            s4 = tot + (SIN_W'(crd[a]) <<< 1) + SIN_W'(crd[a]);
            q1_next[a] = s4[SIN_W-1:F];
        end
    end

    // ---------------- stage 2: reciprocal multiply for /3 ----------------
    logic [PW-1:0] pc2_next [3];
    logic [PW-1:0] pc2_reg  [3];

    always_comb
    begin
        logic [UW-1:0] u;
        for (int a = 0; a < 3; a++)
        begin
            u = UW'(q1_reg[a]) + CELL_BIAS;
            pc2_next[a] = PW'(u) * PW'(CELL_M);
        end
    end

    // ---------------- stage 3: lattice cell and skewed offsets ----------------
    logic [7:0]    l3_next [3];
    logic [7:0]    l3_reg  [3];
    logic [NW-1:0] a3_next [3];
    logic [NW-1:0] a3_reg  [3];

    always_comb
    begin
        logic [LW-1:0] cl [3];
        logic [LW-1:0] lat [3];
        for (int a = 0; a < 3; a++)
        begin
            // the bias is a multiple of 2^10, so the low byte is the cell index
            l3_next[a] = pc2_reg[a][DM +: 8];
            cl[a]      = l3_next[a][LW-1:0];
        end
        // a = 6*x + (sum of other two cells - 5*own cell) * 2^F
        lat[0] = cl[1] + cl[2] - (cl[0] << 2) - cl[0];
        lat[1] = cl[0] + cl[2] - (cl[1] << 2) - cl[1];
        lat[2] = cl[0] + cl[1] - (cl[2] << 2) - cl[2];
        for (int a = 0; a < 3; a++)
            a3_next[a] = xl2_reg[a] * NW'(6) + {lat[a], {F{1'b0}}};
    end

    // ---------------- stage 4: tetrahedron, corner offsets, first hash ----------------
    logic [NW-1:0] n4_next [4][3];
    logic [NW-1:0] n4_reg  [4][3];
    logic [7:0]    ha4_next [4];
    logic [7:0]    ha4_reg  [4];
    logic [7:0]    hb4_next [4];
    logic [7:0]    hb4_reg  [4];
    logic [7:0]    h4_next  [4];
    logic [7:0]    h4_reg   [4];

    always_comb
    begin
        logic       ge_xy, ge_yz, ge_xz;
        logic [2:0] c1, c2;
        logic [2:0] cv [4];
        logic [7:0] hk;
        ge_xy = $signed(a3_reg[0]) >= $signed(a3_reg[1]);
        ge_yz = $signed(a3_reg[1]) >= $signed(a3_reg[2]);
        ge_xz = $signed(a3_reg[0]) >= $signed(a3_reg[2]);
        // corner steps as {i,j,k}
        if (ge_xy)
        begin
            if (ge_yz)
            begin
                c1 = 3'b100; c2 = 3'b110;
            end
            else if (ge_xz)
            begin
                c1 = 3'b100; c2 = 3'b101;
            end
            else
            begin
                c1 = 3'b001; c2 = 3'b101;
            end
        end
        else
        begin
            if (!ge_yz)
            begin
                c1 = 3'b001; c2 = 3'b011;
            end
            else if (!ge_xz)
            begin
                c1 = 3'b010; c2 = 3'b011;
            end
            else
            begin
                c1 = 3'b010; c2 = 3'b110;
            end
        end
        cv[0] = 3'b000;
        cv[1] = c1;
        cv[2] = c2;
        cv[3] = 3'b111;
        for (int cc = 0; cc < 4; cc++)
        begin
            for (int a = 0; a < 3; a++)
                n4_next[cc][a] = a3_reg[a] - (cv[cc][2-a] ? SIX_N : '0) + NW'(cc << F);
            ha4_next[cc] = l3_reg[0] + {7'd0, cv[cc][2]};
            hb4_next[cc] = l3_reg[1] + {7'd0, cv[cc][1]};
            hk           = l3_reg[2] + {7'd0, cv[cc][0]};
            h4_next[cc]  = PERM[hk];
        end
    end

    // ---------------- stage 5: offset /6 multiply, second hash ----------------
    logic [PM_W-1:0] pm5_next [4][3];
    logic [PM_W-1:0] pm5_reg  [4][3];
    logic [7:0]      ha5_reg  [4];
    logic [7:0]      h5_next  [4];
    logic [7:0]      h5_reg   [4];

    always_comb
    begin
        logic signed [VW-1:0] v;
        logic [VW-1:0]        u;
        for (int cc = 0; cc < 4; cc++)
        begin
            for (int a = 0; a < 3; a++)
            begin
                // round to nearest: floor((n*2^(24-F) + 3) / 6)
                v = (VW'($signed(n4_reg[cc][a])) <<< (INT_FRAC - F)) + VW'(3);
                u = {v[VW-1], v[VW-1:1]} + DIV3_BIAS;
                pm5_next[cc][a] = PM_W'(u) * PM_W'(DIV3_R);
            end
            h5_next[cc] = PERM[hb4_reg[cc] + h4_reg[cc]];
        end
    end

    // ---------------- stage 6: offsets at 24 fraction bits, gradient pick ----------------
    logic signed [OFF_W-1:0] off6_next [4][3];
    logic signed [OFF_W-1:0] off6_reg  [4][3];
    logic [3:0]              g6_next   [4];
    logic [3:0]              g6_reg    [4];

    always_comb
    begin
        for (int cc = 0; cc < 4; cc++)
        begin
            for (int a = 0; a < 3; a++)
                off6_next[cc][a] = pm5_reg[cc][a][DIV3_SH +: OFF_W];
            g6_next[cc] = perm_mod12(PERM[ha5_reg[cc] + h5_reg[cc]]);
        end
    end

    // ---------------- stage 7: squares and gradient dot ----------------
    logic [SQ_W-1:0]         sq7_next [4][3];
    logic [SQ_W-1:0]         sq7_reg  [4][3];
    logic signed [DOT_W-1:0] d7_next  [4];
    logic signed [DOT_W-1:0] d7_reg   [4];
    logic signed [DOT_W-1:0] d8_reg   [4];
    logic signed [DOT_W-1:0] d9_reg   [4];
    logic signed [DOT_W-1:0] d10_reg  [4];
    logic signed [DOT_W-1:0] d11_reg  [4];

    always_comb
    begin
        logic signed [R2_W-1:0] sqf;
        for (int cc = 0; cc < 4; cc++)
        begin
            for (int a = 0; a < 3; a++)
            begin
                sqf = R2_W'(off6_reg[cc][a]) * R2_W'(off6_reg[cc][a]);
                sq7_next[cc][a] = sqf[SQ_W-1:0];
            end
            d7_next[cc] = grad_dot(g6_reg[cc], off6_reg[cc][0], off6_reg[cc][1],
                                   off6_reg[cc][2]);
        end
    end

    // ---------------- stage 8: r^2 ----------------
    logic [R2_W-1:0] r2_8_next [4];
    logic [R2_W-1:0] r2_8_reg  [4];

    always_comb
    begin
        for (int cc = 0; cc < 4; cc++)
            r2_8_next[cc] = R2_W'(sq7_reg[cc][0]) + R2_W'(sq7_reg[cc][1])
                          + R2_W'(sq7_reg[cc][2]);
    end

    // ---------------- stage 9: falloff t, rounded ----------------
    logic [T_W-1:0] t9_next   [4];
    logic [T_W-1:0] t9_reg    [4];
    logic           pos9_next [4];
    logic           pos9_reg  [4];
    logic           pos10_reg [4];
    logic           pos11_reg [4];

    always_comb
    begin
        logic [R2_W-1:0] tr;
        for (int cc = 0; cc < 4; cc++)
        begin
            pos9_next[cc] = r2_8_reg[cc] <= C06;
            tr            = C06 - r2_8_reg[cc] + T_RND;
            t9_next[cc]   = tr[INT_FRAC +: T_W];
        end
    end

    // ---------------- stages 10-12: t^2, t^4, contribution ----------------
    logic [TT_W-1:0]         p10_next [4];
    logic [TT_W-1:0]         p10_reg  [4];
    logic [TT_W-1:0]         p11_next [4];
    logic [TT_W-1:0]         p11_reg  [4];
    logic signed [CON_W-1:0] c12_next [4];
    logic signed [CON_W-1:0] c12_reg  [4];

    always_comb
    begin
        logic [TT_W-1:0] tr2;
        logic [TT_W-1:0] tr4;
        for (int cc = 0; cc < 4; cc++)
        begin
            p10_next[cc] = TT_W'(t9_reg[cc]) * TT_W'(t9_reg[cc]);
            tr2          = p10_reg[cc] + TT_RND;
            p11_next[cc] = TT_W'(tr2[INT_FRAC +: T_W]) * TT_W'(tr2[INT_FRAC +: T_W]);
            tr4          = p11_reg[cc] + TT_RND;
            if (pos11_reg[cc])
                c12_next[cc] = $signed(CON_W'(tr4[INT_FRAC +: T_W])) * CON_W'(d11_reg[cc]);
            else
                c12_next[cc] = '0;
        end
    end

    // ---------------- stage 13: sum; output: scale, round, saturate ----------------
    logic signed [SUM_W-1:0] sum13_next;
    logic signed [SUM_W-1:0] sum13_reg;

    always_comb
    begin
        logic signed [SUM_W-1:0] rr;
        sum13_next = SUM_W'(c12_reg[0]) + SUM_W'(c12_reg[1])
                   + SUM_W'(c12_reg[2]) + SUM_W'(c12_reg[3]);
        rr = (sum13_reg + OUT_RND) >>> SH;
        if (rr > SAT_HI)
            o_noise_next = SAT_HI[OUT_W-1:0];
        else if (rr < SAT_LO)
            o_noise_next = SAT_LO[OUT_W-1:0];
        else
            o_noise_next = rr[OUT_W-1:0];
    end

    // payload registers: no reset, move with the pipe
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            for (int a = 0; a < 3; a++)
            begin
                q1_reg[a]  <= q1_next[a];
                xl1_reg[a] <= crd[a][NW-1:0];
                pc2_reg[a] <= pc2_next[a];
                xl2_reg[a] <= xl1_reg[a];
                l3_reg[a]  <= l3_next[a];
                a3_reg[a]  <= a3_next[a];
            end
            for (int cc = 0; cc < 4; cc++)
            begin
                for (int a = 0; a < 3; a++)
                begin
                    n4_reg[cc][a]   <= n4_next[cc][a];
                    pm5_reg[cc][a]  <= pm5_next[cc][a];
                    off6_reg[cc][a] <= off6_next[cc][a];
                    sq7_reg[cc][a]  <= sq7_next[cc][a];
                end
                ha4_reg[cc]   <= ha4_next[cc];
                hb4_reg[cc]   <= hb4_next[cc];
                h4_reg[cc]    <= h4_next[cc];
                ha5_reg[cc]   <= ha4_reg[cc];
                h5_reg[cc]    <= h5_next[cc];
                g6_reg[cc]    <= g6_next[cc];
                d7_reg[cc]    <= d7_next[cc];
                d8_reg[cc]    <= d7_reg[cc];
                d9_reg[cc]    <= d8_reg[cc];
                d10_reg[cc]   <= d9_reg[cc];
                d11_reg[cc]   <= d10_reg[cc];
                r2_8_reg[cc]  <= r2_8_next[cc];
                t9_reg[cc]    <= t9_next[cc];
                pos9_reg[cc]  <= pos9_next[cc];
                pos10_reg[cc] <= pos9_reg[cc];
                pos11_reg[cc] <= pos10_reg[cc];
                p10_reg[cc]   <= p10_next[cc];
                p11_reg[cc]   <= p11_next[cc];
                c12_reg[cc]   <= c12_next[cc];
            end
            sum13_reg   <= sum13_next;
            o_noise_reg <= o_noise_next;
        end
    end

endmodule

[tb/sv/tb_simplex_noise_3d.sv]
`timescale 1ns / 1ps
// Self-checking testbench for simplex_noise_3d: directed and random points with idle and stall
// traffic on both channels, with each noise value checked against an in-bench predictor.
// Depends on snx_pkg and the channel interfaces in snx_if.sv.

import snx_pkg::*;

// Holds the expected noise values in order and checks each output transaction.
class noise_scoreboard;
    localparam int FB  = 16;
    localparam int OFB = 14;

    shortint pending_noise[$];
    int      errors;

    // gradient set: one row per edge midpoint of a cube
    int grad_set[12][3] = '{
        '{1, 1, 0}, '{-1, 1, 0}, '{1, -1, 0}, '{-1, -1, 0},
        '{1, 0, 1}, '{-1, 0, 1}, '{1, 0, -1}, '{-1, 0, -1},
        '{0, 1, 1}, '{0, -1, 1}, '{0, 1, -1}, '{0, -1, -1}
    };

    function new();
        errors = 0;
    endfunction

    static function longint floor_div(longint a, longint d);
        longint q;
        q = a / d;
        if ((a % d) != 0 && a < 0)
            q--;
        return q;
    endfunction

    static function int gradient_of(longint a, longint b, longint c);
        int h;
        h = PERM[c & 255];
        h = PERM[(b + h) & 255];
        h = PERM[(a + h) & 255];
        return h % 12;
    endfunction

    // exact offset in units of 1/(6*2^FB), rounded to 24 fraction bits
    static function longint to_q24(longint n);
        return floor_div(n * (longint'(1) << 24) + (longint'(3) << FB), longint'(6) << FB);
    endfunction

    function longint corner_term(longint nx, longint ny, longint nz, int g);
        longint x, y, z, t, t1, t2, t4, d;
        x = to_q24(nx);
        y = to_q24(ny);
        z = to_q24(nz);
        t = 64'sd168884986026394 - (x * x + y * y + z * z);
        if (t < 0)
            return 0;
        t1 = (t + (longint'(1) << 23)) >>> 24;
        t2 = (t1 * t1 + (longint'(1) << 23)) >>> 24;
        t4 = (t2 * t2 + (longint'(1) << 23)) >>> 24;
        d  = grad_set[g][0] * x + grad_set[g][1] * y + grad_set[g][2] * z;
        return t4 * d;
    endfunction

    function shortint noise_at(int px, int py, int pz);
        longint x, y, z, one, s, i, j, k, tt, six, ax, ay, az, sum, r;
        int i1, j1, k1, i2, j2, k2;
        x = px; y = py; z = pz;
        one = longint'(1) << FB;
        s   = x + y + z;
        i   = floor_div(3 * x + s, 3 * one);
        j   = floor_div(3 * y + s, 3 * one);
        k   = floor_div(3 * z + s, 3 * one);
        tt  = (i + j + k) * one;
        six = 6 * one;
        ax  = 6 * (x - i * one) + tt;
        ay  = 6 * (y - j * one) + tt;
        az  = 6 * (z - k * one) + tt;
        // pick the tetrahedron from the ordering of the exact offsets
        if (ax >= ay)
        begin
            if (ay >= az)
            begin
                i1 = 1; j1 = 0; k1 = 0; i2 = 1; j2 = 1; k2 = 0;
            end
            else if (ax >= az)
            begin
                i1 = 1; j1 = 0; k1 = 0; i2 = 1; j2 = 0; k2 = 1;
            end
            else
            begin
                i1 = 0; j1 = 0; k1 = 1; i2 = 1; j2 = 0; k2 = 1;
            end
        end
        else
        begin
            if (ay < az)
            begin
                i1 = 0; j1 = 0; k1 = 1; i2 = 0; j2 = 1; k2 = 1;
            end
            else if (ax < az)
            begin
                i1 = 0; j1 = 1; k1 = 0; i2 = 0; j2 = 1; k2 = 1;
            end
            else
            begin
                i1 = 0; j1 = 1; k1 = 0; i2 = 1; j2 = 1; k2 = 0;
            end
        end
        sum = corner_term(ax, ay, az, gradient_of(i, j, k));
        sum += corner_term(ax - i1 * six + one, ay - j1 * six + one, az - k1 * six + one,
                           gradient_of(i + i1, j + j1, k + k1));
        sum += corner_term(ax - i2 * six + 2 * one, ay - j2 * six + 2 * one,
                           az - k2 * six + 2 * one, gradient_of(i + i2, j + j2, k + k2));
        sum += corner_term(ax - six + 3 * one, ay - six + 3 * one, az - six + 3 * one,
                           gradient_of(i + 1, j + 1, k + 1));
        // scale by 32 into OFB fraction bits: shift of 48 - 5 - OFB
        r = (sum + (longint'(1) << (42 - OFB))) >>> (43 - OFB);
        if (r > 32767)
            r = 32767;
        if (r < -32768)
            r = -32768;
        return shortint'(r);
    endfunction

    function void note_point(int px, int py, int pz);
        pending_noise.push_back(noise_at(px, py, pz));
    endfunction

    function void check_noise(shortint got);
        shortint want;
        if (pending_noise.size() == 0)
        begin
            $display("%0t: unexpected noise transaction, actual %0d", $time, got);
            errors++;
            return;
        end
        want = pending_noise.pop_front();
        if (got !== want)
        begin
            $display("%0t: noise_value mismatch, expected %0d, actual %0d", $time, want, got);
            errors++;
        end
    endfunction
endclass

module tb_simplex_noise_3d;

    logic clk;
    logic rst_n;

    snx_in_if  in_ch ();
    snx_out_if out_ch ();

    simplex_noise_3d dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    noise_scoreboard sb = new();

    // during the calm window neither side idles, so the pipe runs flat out
    bit calm;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // hard ceiling on run length
    initial
    begin
        #5ms;
        $display("Simulation FAILED");
        $finish;
    end

    function automatic bit take_a_break();
        return !calm && ($urandom_range(99) < 30);
    endfunction

    // Present one point from a falling edge and hold it until a transaction
    // takes it; random idle cycles are inserted beforehand.
    task automatic send_point(int px, int py, int pz);
        while (take_a_break())
        begin
            @(negedge clk);
            in_ch.valid <= 1'b0;
        end
        @(negedge clk);
        in_ch.valid   <= 1'b1;
        in_ch.x_coord <= px;
        in_ch.y_coord <= py;
        in_ch.z_coord <= pz;
        do
            @(posedge clk);
        while (!in_ch.ready);
        sb.note_point(px, py, pz);
    endtask

    // random point: a mix of small lattice neighbourhoods, whole numbers (x and y
    // negative, give or take one LSB) and the full 32-bit range
    task automatic send_random_point();
        int px, py, pz;
        int kind;
        kind = $urandom_range(9);
        if (kind < 4)
        begin
            px = $urandom_range(1048576) - 524288;
            py = $urandom_range(1048576) - 524288;
            pz = $urandom_range(1048576) - 524288;
        end
        else if (kind < 6)
        begin
            px = -int'($urandom_range(300)) * 65536 + $urandom_range(2) - 1;
            py = -int'($urandom_range(300)) * 65536 + $urandom_range(2) - 1;
            pz = int'($urandom_range(600)) * 65536 - 300 * 65536;
        end
        else
        begin
            px = $urandom;
            py = $urandom;
            pz = $urandom;
        end
        send_point(px, py, pz);
    endtask

    // receiver: stalls at random except during the calm window
    always @(negedge clk)
        out_ch.ready <= !take_a_break();

    always @(posedge clk)
        if (rst_n && out_ch.valid && out_ch.ready)
            sb.check_noise(out_ch.noise_value);

    initial
    begin
        int n;
        in_ch.valid   = 1'b0;
        in_ch.x_coord = '0;
        in_ch.y_coord = '0;
        in_ch.z_coord = '0;
        out_ch.ready  = 1'b0;
        calm  = 1'b0;
        rst_n = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: origin, field extremes, negative whole numbers,
        // ties between offsets, each tetrahedron, lattice wrap-around
        send_point(0, 0, 0);
        send_point(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
        send_point(32'sh80000000, 32'sh80000000, 32'sh80000000);
        send_point(32'sh7FFFFFFF, 32'sh80000000, 0);
        send_point(32'sh80000000, 0, 32'sh7FFFFFFF);
        send_point(-65536, -65536, -65536);
        send_point(-65536, 0, 65536);
        send_point(-131072, -196608, -65536);
        send_point(16384, 16384, 16384);
        send_point(30000, 20000, 10000);
        send_point(30000, 10000, 20000);
        send_point(10000, 30000, 20000);
        send_point(20000, 30000, 10000);
        send_point(10000, 20000, 30000);
        send_point(20000, 10000, 30000);
        send_point(40000, 40000, 10000);
        send_point(10000, 40000, 40000);
        send_point(256 * 65536 + 1000, 255 * 65536 + 900, -256 * 65536 + 12345);
        send_point(-1, -1, -1);
        send_point(1, 1, 1);
        send_point(32768, 32768, 32768);
        send_point(-32768, 49152, 8192);

        for (n = 0; n < 1800; n++)
        begin
            calm = (n >= 700 && n < 1000);
            send_random_point();
        end
        calm = 1'b0;

        @(negedge clk);
        in_ch.valid <= 1'b0;

        // drain: the pipe is 14 deep, stalls included this is ample
        n = 0;
        while (sb.pending_noise.size() != 0 && n < 20000)
        begin
            @(posedge clk);
            n++;
        end
        if (sb.pending_noise.size() != 0)
        begin
            $display("%0t: %0d noise values never arrived", $time, sb.pending_noise.size());
            $display("Simulation FAILED");
            $finish;
        end
        else
        begin
            // watch for stray transactions past the last expected one
            repeat (40) @(posedge clk);
            if (sb.errors == 0)
                $display("Simulation PASSED");
            else
                $display("Simulation FAILED");
            $finish;
        end
    end

endmodule

[filelist.f]
src/snx_pkg.sv
src/snx_if.sv
src/simplex_noise_3d.sv
tb/sv/tb_simplex_noise_3d.sv
